// File: rtl/otr_even_mansour_block_encrypt_assert.svh
// Assertion macros shared by the block's RTL files; they use clk and arst_n of the module.
`ifndef OTR_EVEN_MANSOUR_BLOCK_ENCRYPT_ASSERT_SVH
`define OTR_EVEN_MANSOUR_BLOCK_ENCRYPT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OTR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("otr assertion failed");

// Next-cycle implication, checked out of reset.
`define OTR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("otr assertion failed");

`endif

// File: rtl/otr_pkg.sv
// Package with the permutation constants, the payload carried beside it, and helper functions.
package otr_pkg;

	localparam int ROUNDS         = 32;
	localparam int ROUNDS_PER_STG = 2;
	localparam int STAGES         = ROUNDS / ROUNDS_PER_STG;

	localparam logic [63:0] GF_POLY = 64'h0000_0000_0000_001B;

	localparam logic [4:0] ROT [8] = '{5'd1, 5'd29, 5'd4, 5'd8, 5'd17, 5'd12, 5'd3, 5'd14};

	typedef struct packed {
		logic [63:0] first_blk;
		logic [63:0] second_blk;
	} side_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
		logic [5:0] rr;
		rr = {1'b0, r};
		return (v << rr) | (v >> (6'd32 - rr));
	endfunction

	// One ARX round on {hi, lo}.
	function automatic logic [63:0] otr_round(input logic [63:0] x, input logic [4:0] idx);
		logic [31:0] hi;
		logic [31:0] lo;
		hi = x[63:32] + x[31:0];
		lo = rotl32(x[31:0], ROT[idx[2:0]]) ^ hi;
		lo = lo + {27'd0, idx};
		return {hi, lo};
	endfunction

	// Multiply by x in GF(2^64).
	function automatic logic [63:0] gf_double(input logic [63:0] v);
		return {v[62:0], 1'b0} ^ (v[63] ? GF_POLY : 64'd0);
	endfunction

endpackage

// File: rtl/otr_even_mansour_block_encrypt.sv
// Top level: OTR-style block encryption over a 64-bit Even-Mansour cipher, fully pipelined.
// Accepts one transaction per clock while in_ready is high and returns one ciphertext block per
// transaction, in order. The path is 16 stages for E(K,nonce), 16 stages for the second
// encryption (two ARX rounds per stage), and one output register. The whole pipeline
// advances only while the output register is empty or being taken, so a held output stalls
// every stage and in_ready drops with it. key is registered on key_we and used at the first
// pipe's input, the masking and the output; write it only while no transaction is in flight.
`include "otr_even_mansour_block_encrypt_assert.svh"

module otr_even_mansour_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_we,
	input  logic [63:0] key,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] nonce,
	input  logic [63:0] first_block,
	input  logic [63:0] second_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_block
);
	import otr_pkg::*;

	logic [63:0] key_q;
	logic        out_valid_q;
	logic [63:0] cipher_block_q;
	logic        advance;

	side_t       side_a;
	logic        pa_vld;
	logic [63:0] pa_data;
	side_t       pa_side;
	logic [63:0] mask;
	logic [63:0] pb_in;
	side_t       side_b;
	logic        pb_vld;
	logic [63:0] pb_data;
	side_t       pb_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_we) begin
			key_q <= key;
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;

	assign side_a = '{first_blk: first_block, second_blk: second_block};

	otr_perm_pipe u_perm_nonce (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.vld_in   (in_valid),
		.data_in  (key_q ^ nonce),
		.side_in  (side_a),
		.vld_out  (pa_vld),
		.data_out (pa_data),
		.side_out (pa_side)
	);

	// Mask L = 4 * E(K, nonce); whiten the masked block for the second pass.
	assign mask   = gf_double(gf_double(pa_data ^ key_q));
	assign pb_in  = key_q ^ mask ^ pa_side.first_blk;
	assign side_b = '{first_blk: 64'd0, second_blk: pa_side.second_blk};

	otr_perm_pipe u_perm_block (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.vld_in   (pa_vld),
		.data_in  (pb_in),
		.side_in  (side_b),
		.vld_out  (pb_vld),
		.data_out (pb_data),
		.side_out (pb_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= pb_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cipher_block_q <= pb_data ^ key_q ^ pb_side.second_blk;
		end
	end

	assign out_valid    = out_valid_q;
	assign cipher_block = cipher_block_q;

	// A new result comes only from a valid pipeline output moved on an advance.
	`OTR_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(pb_vld) && $past(advance))
	// A finished item waiting on a stall is not dropped.
	`OTR_ASSERT_NXT(a_pb_hold, pb_vld && !advance, pb_vld)
endmodule

// File: rtl/otr_perm_pipe.sv
// Pipelined 32-round ARX permutation, two rounds per stage, with sideband payload.
`include "otr_even_mansour_block_encrypt_assert.svh"

module otr_perm_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          vld_in,
	input  logic [63:0]   data_in,
	input  otr_pkg::side_t side_in,
	output logic          vld_out,
	output logic [63:0]   data_out,
	output otr_pkg::side_t side_out
);
	import otr_pkg::*;

	// Stage g registers hold the state after rounds 2g and 2g+1.
	logic [STAGES-1:0] vld_s;
	logic [63:0]       data_s [STAGES];
	side_t             side_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [63:0] src;
		side_t       src_side;
		logic [63:0] nxt;

		if (g == 0) begin : g_first
			assign src      = data_in;
			assign src_side = side_in;
		end else begin : g_rest
			assign src      = data_s[g-1];
			assign src_side = side_s[g-1];
		end

		always_comb begin
			nxt = otr_round(otr_round(src, 5'(ROUNDS_PER_STG * g)),
				5'(ROUNDS_PER_STG * g + 1));
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				data_s[g] <= nxt;
				side_s[g] <= src_side;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[STAGES-2:0], vld_in};
		end
	end

	assign vld_out  = vld_s[STAGES-1];
	assign data_out = data_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

	// Occupancy moves by at most one transaction per cycle.
	`OTR_ASSERT_IMP(a_occ_step, 1'b1,
		($countones(vld_s) <= $past($countones(vld_s)) + 1) &&
		($countones(vld_s) + 1 >= $past($countones(vld_s))))
	// A stall freezes every valid bit.
	`OTR_ASSERT_NXT(a_stall_freeze, !advance, $stable(vld_s))
endmodule
